// ===== rtl/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer package
// Shared codes, widths and the brush point record passed between modules.
// ----------------------------------------------------------------------------
package tlr_pkg;

   localparam int MAX_THICKNESS_DEF = 15;

   localparam int COORD_W  = 13;
   localparam int CUR_W    = 14;
   localparam int POS_W    = 16;
   localparam int DIM_W    = 13;
   localparam int PIX_W    = 12;
   localparam int INDEX_W  = 24;
   localparam int COLOR_W  = 32;
   localparam int THICK_W  = 4;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd720;

   typedef struct packed {
      logic [POS_W-1:0]   px;
      logic [POS_W-1:0]   py;
      logic               done;
      logic [COLOR_W-1:0] color;
   } point_type;

endpackage

// ===== rtl/tlr_csr.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer configuration registers
// Holds the frame width and height behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tlr_csr
   import tlr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [DIM_W-1:0]  frame_width,
   output logic [DIM_W-1:0]  frame_height
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign frame_width  = width_ff;
   assign frame_height = height_ff;

endmodule

// ===== rtl/tlr_walker.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer line walker
// Holds the Bresenham state and the brush counters, presents the current
// brush point and advances by one brush pixel on every tick item while busy.
// ----------------------------------------------------------------------------
module tlr_walker
   import tlr_pkg::*;
#(
   parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_load,
   input  logic               tick_step,
   input  logic [COORD_W-1:0] start_x,
   input  logic [COORD_W-1:0] start_y,
   input  logic [COORD_W-1:0] end_x,
   input  logic [COORD_W-1:0] end_y,
   input  logic [COLOR_W-1:0] color,
   input  logic [THICK_W-1:0] thickness,
   output logic               busy,
   output point_type          point
);

   localparam int HALF_MAX = MAX_THICKNESS / 2;
   localparam int HALF_W   = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
   localparam int DX_W     = (HALF_MAX > 0) ? $clog2(2 * HALF_MAX + 1) : 1;

   logic               busy_ff, busy_in;
   logic [CUR_W-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_W-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [CUR_W-1:0]   delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic               dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic [15:0]        err_ff, err_in;
   logic [DX_W-1:0]    brush_dx_ff, brush_dx_in, brush_dy_ff, brush_dy_in;
   logic [HALF_W-1:0]  brush_half_ff, brush_half_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   logic [CUR_W-1:0]   sx, sy, gx, gy, diff_x, diff_y;
   logic [4:0]         thick_clamped;
   logic [DX_W-1:0]    brush_limit;
   logic               at_goal;
   logic [17:0]        e2;
   logic               step_x, step_y;
   logic [16:0]        err_next;

   assign sx = {start_x[COORD_W-1], start_x};
   assign sy = {start_y[COORD_W-1], start_y};
   assign gx = {end_x[COORD_W-1], end_x};
   assign gy = {end_y[COORD_W-1], end_y};
   assign diff_x = gx - sx;
   assign diff_y = gy - sy;

   assign thick_clamped = (5'(thickness) > 5'(MAX_THICKNESS)) ?
                          5'(MAX_THICKNESS) : 5'(thickness);

   assign brush_limit = DX_W'({brush_half_ff, 1'b0});
   assign at_goal = (cur_x_ff == {goal_x_ff[COORD_W-1], goal_x_ff}) &&
                    (cur_y_ff == {goal_y_ff[COORD_W-1], goal_y_ff});

   assign e2     = {err_ff[15], err_ff, 1'b0};
   assign step_x = $signed(e2) > $signed(18'd0 - 18'(delta_y_ff));
   assign step_y = $signed(e2) < $signed(18'(delta_x_ff));

   always_comb begin
      err_next = {err_ff[15], err_ff};
      if (step_x) begin
         err_next = err_next - 17'(delta_y_ff);
      end
      if (step_y) begin
         err_next = err_next + 17'(delta_x_ff);
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      dir_x_neg_in  = dir_x_neg_ff;
      dir_y_neg_in  = dir_y_neg_ff;
      err_in        = err_ff;
      brush_dx_in   = brush_dx_ff;
      brush_dy_in   = brush_dy_ff;
      brush_half_in = brush_half_ff;
      color_in      = color_ff;
      if (start_load) begin
         busy_in       = 1'b1;
         cur_x_in      = sx;
         cur_y_in      = sy;
         goal_x_in     = end_x;
         goal_y_in     = end_y;
         delta_x_in    = diff_x[CUR_W-1] ? (CUR_W'(0) - diff_x) : diff_x;
         delta_y_in    = diff_y[CUR_W-1] ? (CUR_W'(0) - diff_y) : diff_y;
         dir_x_neg_in  = !($signed(sx) < $signed(gx));
         dir_y_neg_in  = !($signed(sy) < $signed(gy));
         err_in        = 16'(delta_x_in) - 16'(delta_y_in);
         brush_dx_in   = '0;
         brush_dy_in   = '0;
         brush_half_in = HALF_W'(thick_clamped >> 1);
         color_in      = color;
      end else if (tick_step && busy_ff) begin
         if (brush_dy_ff < brush_limit) begin
            brush_dy_in = brush_dy_ff + DX_W'(1);
         end else begin
            brush_dy_in = '0;
            if (brush_dx_ff < brush_limit) begin
               brush_dx_in = brush_dx_ff + DX_W'(1);
            end else begin
               brush_dx_in = '0;
               if (at_goal) begin
                  busy_in = 1'b0;
               end else begin
                  err_in = err_next[15:0];
                  if (step_x) begin
                     cur_x_in = dir_x_neg_ff ? cur_x_ff - CUR_W'(1) : cur_x_ff + CUR_W'(1);
                  end
                  if (step_y) begin
                     cur_y_in = dir_y_neg_ff ? cur_y_ff - CUR_W'(1) : cur_y_ff + CUR_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         brush_dx_ff   <= '0;
         brush_dy_ff   <= '0;
         brush_half_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         brush_dx_ff   <= brush_dx_in;
         brush_dy_ff   <= brush_dy_in;
         brush_half_ff <= brush_half_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      goal_x_ff    <= goal_x_in;
      goal_y_ff    <= goal_y_in;
      delta_x_ff   <= delta_x_in;
      delta_y_ff   <= delta_y_in;
      dir_x_neg_ff <= dir_x_neg_in;
      dir_y_neg_ff <= dir_y_neg_in;
      err_ff       <= err_in;
      color_ff     <= color_in;
   end

   assign busy        = busy_ff;
   assign point.px    = {{(POS_W-CUR_W){cur_x_ff[CUR_W-1]}}, cur_x_ff} +
                        POS_W'(brush_dx_ff) - POS_W'(brush_half_ff);
   assign point.py    = {{(POS_W-CUR_W){cur_y_ff[CUR_W-1]}}, cur_y_ff} +
                        POS_W'(brush_dy_ff) - POS_W'(brush_half_ff);
   assign point.done  = (brush_dy_ff >= brush_limit) && (brush_dx_ff >= brush_limit) &&
                        at_goal;
   assign point.color = color_ff;

endmodule

// ===== rtl/tlr_pixel_out.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer pixel output stage
// Clips a brush point against the frame, forms the linear index and holds
// the result item in the output register until it is taken.
// ----------------------------------------------------------------------------
module tlr_pixel_out
   import tlr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  point_type          point,
   input  logic [DIM_W-1:0]   frame_width,
   input  logic [DIM_W-1:0]   frame_height,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_write,
   output logic [PIX_W-1:0]   rsp_pixel_x,
   output logic [PIX_W-1:0]   rsp_pixel_y,
   output logic [INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0] rsp_pixel_color,
   output logic               rsp_done_res
);

   logic               valid_ff, valid_in;
   logic               write_ff;
   logic [PIX_W-1:0]   x_ff, y_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               done_ff;

   logic               in_x, in_y, in_frame;
   logic [PIX_W+DIM_W-1:0] row_base;
   logic [INDEX_W-1:0] index;

   assign in_x = (point.px[POS_W-1:PIX_W] == '0) &&
                 ({1'b0, point.px[PIX_W-1:0]} < frame_width);
   assign in_y = (point.py[POS_W-1:PIX_W] == '0) &&
                 ({1'b0, point.py[PIX_W-1:0]} < frame_height);
   assign in_frame = in_x && in_y;

   assign row_base = point.py[PIX_W-1:0] * frame_width;
   assign index    = row_base[INDEX_W-1:0] + INDEX_W'(point.px[PIX_W-1:0]);

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         write_ff <= in_frame;
         x_ff     <= in_frame ? point.px[PIX_W-1:0] : '0;
         y_ff     <= in_frame ? point.py[PIX_W-1:0] : '0;
         index_ff <= in_frame ? index : '0;
         color_ff <= point.color;
         done_ff  <= point.done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_write       = write_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_done_res    = done_ff;

endmodule

// ===== rtl/thick_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer core
// Bresenham line walker with a square brush, frame clipping and index output.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid / req_stall  op, endpoints, colour, thickness
//   rsp_      out        rsp_valid / rsp_stall  write, x, y, index, colour, done
//   APB       in/out     psel, penable, pready  frame width (0x0), height (0x4)
//
// A tick item on an active line is turned into a brush pixel by the clip and
// index logic and lands in the output register on the next edge.
// One item per clock is sustained while the output register drains.
// Reset is synchronous and active high; it leaves the walker idle.
// While the output register holds an item that is stalled, req_stall is high.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_core
   import tlr_pkg::*;
#(
   parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_end_x,
   input  logic [COORD_W-1:0] req_end_y,
   input  logic [COLOR_W-1:0] req_color,
   input  logic [THICK_W-1:0] req_thickness,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_write,
   output logic [PIX_W-1:0]   rsp_pixel_x,
   output logic [PIX_W-1:0]   rsp_pixel_y,
   output logic [INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0] rsp_pixel_color,
   output logic               rsp_done_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   logic             req_accept;
   logic             start_load;
   logic             tick_step;
   logic             emit;
   logic             busy;
   point_type        point;
   logic [DIM_W-1:0] frame_width;
   logic [DIM_W-1:0] frame_height;

   assign req_stall  = rsp_valid && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign start_load = req_accept && (req_op == OP_START);
   assign tick_step  = req_accept && (req_op == OP_TICK);
   assign emit       = tick_step && busy;

   tlr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   tlr_walker #(
      .MAX_THICKNESS (MAX_THICKNESS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .start_load (start_load),
      .tick_step  (tick_step),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .color      (req_color),
      .thickness  (req_thickness),
      .busy       (busy),
      .point      (point)
   );

   tlr_pixel_out u_pixel_out (
      .clock           (clock),
      .reset           (reset),
      .load            (emit),
      .point           (point),
      .frame_width     (frame_width),
      .frame_height    (frame_height),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_write       (rsp_write),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_done_res    (rsp_done_res)
   );

   a_emit_gives_item: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("A tick on an active line did not produce an item.");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && point.done) |=> !busy)
      else $error("The walker stayed busy after the final brush pixel.");

   a_clipped_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write) |->
      (rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_index == '0))
      else $error("A clipped item carries a non-zero position.");

   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start_load) |=> !busy)
      else $error("The walker became busy without a start item.");

endmodule
